// ===== src/lrf_pkg.sv =====
package lrf_pkg;

    // frame limits and link codes
    localparam int unsigned MAX_FRAME_DEF = 1024;
    localparam int unsigned LEN_W         = 11;
    localparam logic [7:0]  SYNC_BYTE     = 8'd170;
    localparam logic [7:0]  ACK_BYTE      = 8'd80;
    localparam logic [7:0]  CMD_SET_LEVEL = 8'd1;
    localparam int unsigned HEADER_BYTES  = 5;
    localparam logic [7:0]  FIXED_BYTES   = 8'd8;

    // queue between classifier and parser
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // host action codes
    localparam logic ACT_RX_BYTE = 1'b0;
    localparam logic ACT_HOST    = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic [7:0] cmd_kind;
        logic [7:0] new_level;
    } t_in;

    typedef struct packed {
        logic             tx_valid;
        logic [7:0]       tx_byte;
        logic             frame_valid;
        logic [7:0]       frame_byte;
        logic             frame_done;
        logic             frame_abort;
        logic [LEN_W-1:0] frame_length;
    } t_out;

    // class of a queued transaction
    typedef enum logic [1:0] {
        KIND_LEVEL,
        KIND_SYNC,
        KIND_DATA
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_qent;

    // queue head as seen by the parser
    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qhead;

    // parse phases of a frame
    typedef enum logic [4:0] {
        PH_HDR,
        PH_LVL_LEN,
        PH_LVL,
        PH_MSG_LEN,
        PH_MSG,
        PH_FIXED,
        PH_FILE_LEN,
        PH_FILE,
        PH_FUNC_LEN,
        PH_FUNC,
        PH_TAG_CNT,
        PH_TAG_LEN,
        PH_TAG,
        PH_DATA_CNT,
        PH_ITEM_TYPE,
        PH_NAME_LEN,
        PH_NAME,
        PH_VAL_LEN,
        PH_VAL,
        PH_DONE
    } t_phase;

endpackage

// ===== src/log_record_framer_core.sv =====
// log record framer
// input channel: i_in_valid / o_in_stall with payload i_in_data; a transaction is
// either a byte from the serial link or a host command. output channel:
// o_out_valid / i_out_stall with payload o_out_data, at most one result per
// input transaction (sync acknowledge, passed frame byte with done/abort flags,
// or a level byte for the transmit side).
// throughput: one transaction per cycle while o_in_stall is low. a result is held
// first in the queue and then in the parser's output register after its input
// transaction is accepted.
// a four-entry queue sits between the classifier and the parser, so input keeps
// flowing for up to four transactions while the output is stalled; o_in_stall
// rises only when that queue is full. unknown host commands are dropped at the
// classifier and take no slot; bytes dropped while hunting still take a slot
// until the parser pops them.
// reset (synchronous, active low) empties the queue and the output register,
// puts the parser into hunting for the sync byte and clears the stored level.
module log_record_framer_core #(
    parameter int unsigned MAX_FRAME = lrf_pkg::MAX_FRAME_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lrf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lrf_pkg::t_out o_out_data
);
    import lrf_pkg::*;

    logic   keep;
    t_qent  ent;
    logic   q_full;
    t_qhead q_head;
    logic   q_pop;

    // classifier
    lrf_front u_front (
        .i_in   (i_in_data),
        .o_keep (keep),
        .o_ent  (ent)
    );

    // decoupling queue
    lrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && keep),
        .i_ent   (ent),
        .o_full  (q_full),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    assign o_in_stall = q_full;

    // frame parser and output register
    lrf_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // a done frame always carries its byte and the level reply
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_done |->
            o_out_data.frame_valid && o_out_data.tx_valid)
        else $error("frame_done without frame byte or level reply");

    // done and abort never together
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.frame_done && o_out_data.frame_abort))
        else $error("frame_done and frame_abort together");

    // every result carries something
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.tx_valid || o_out_data.frame_valid))
        else $error("empty result");

    // the queue fills only behind a stalled output
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("queue filled while output was free");

endmodule

// ===== src/lrf_front.sv =====
module lrf_front (
    input  lrf_pkg::t_in   i_in,
    output logic           o_keep,
    output lrf_pkg::t_qent o_ent
);
    import lrf_pkg::*;

    // classify: level command, sync byte or plain byte; other commands are dropped
    always_comb begin
        o_keep     = 1'b1;
        o_ent.kind = KIND_DATA;
        o_ent.data = i_in.rx_byte;
        if (i_in.action == ACT_HOST) begin
            o_keep     = (i_in.cmd_kind == CMD_SET_LEVEL);
            o_ent.kind = KIND_LEVEL;
            o_ent.data = i_in.new_level;
        end else if (i_in.rx_byte == SYNC_BYTE) begin
            o_ent.kind = KIND_SYNC;
        end
    end

endmodule

// ===== src/lrf_queue.sv =====
module lrf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lrf_pkg::t_qent  i_ent,
    output logic            o_full,
    output lrf_pkg::t_qhead o_head,
    input  logic            i_pop
);
    import lrf_pkg::*;

    t_qent                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full       = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.ent   = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_ent;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/lrf_back.sv =====
module lrf_back #(
    parameter int unsigned MAX_FRAME = lrf_pkg::MAX_FRAME_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lrf_pkg::t_qhead i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output lrf_pkg::t_out   o_out_data
);
    import lrf_pkg::*;

    localparam int unsigned CW = $clog2(MAX_FRAME + 1);

    logic          r_hunting,     n_hunting;
    t_phase        r_phase,       n_phase;
    logic [7:0]    r_field_left,  n_field_left;
    logic [7:0]    r_tags_left,   n_tags_left;
    logic [7:0]    r_items_left,  n_items_left;
    logic [CW-1:0] r_byte_count,  n_byte_count;
    logic [7:0]    r_level,       n_level;
    logic          r_out_valid;
    t_out          r_out;

    logic          produce;
    t_out          res;
    logic [7:0]    b;
    logic [CW-1:0] cnt_inc;
    logic [7:0]    fl_dec;
    logic [7:0]    tl_dec;
    logic [7:0]    il_dec;
    t_phase        adv_phase;
    logic [7:0]    adv_fl;
    logic [7:0]    adv_tl;
    logic [7:0]    adv_il;

    // take the queue head whenever the output register is free or draining
    assign o_pop   = i_head.valid && (!r_out_valid || !i_out_stall);
    assign b       = i_head.ent.data;
    assign cnt_inc = r_byte_count + CW'(1);
    assign fl_dec  = r_field_left - 8'd1;
    assign tl_dec  = r_tags_left - 8'd1;
    assign il_dec  = r_items_left - 8'd1;

    // phase walk for one frame byte
    always_comb begin
        adv_phase = r_phase;
        adv_fl    = r_field_left;
        adv_tl    = r_tags_left;
        adv_il    = r_items_left;
        unique case (r_phase)
            PH_LVL_LEN: begin
                adv_fl    = b;
                adv_phase = (b != '0) ? PH_LVL : PH_MSG_LEN;
            end
            PH_LVL: begin
                adv_fl    = fl_dec;
                adv_phase = (fl_dec == '0) ? PH_MSG_LEN : PH_LVL;
            end
            PH_MSG_LEN: begin
                if (b != '0) begin
                    adv_fl    = b;
                    adv_phase = PH_MSG;
                end else begin
                    adv_fl    = FIXED_BYTES;
                    adv_phase = PH_FIXED;
                end
            end
            PH_MSG: begin
                if (fl_dec == '0) begin
                    adv_fl    = FIXED_BYTES;
                    adv_phase = PH_FIXED;
                end else begin
                    adv_fl    = fl_dec;
                end
            end
            PH_FIXED: begin
                adv_fl    = fl_dec;
                adv_phase = (fl_dec == '0) ? PH_FILE_LEN : PH_FIXED;
            end
            PH_FILE_LEN: begin
                adv_fl    = b;
                adv_phase = (b != '0) ? PH_FILE : PH_FUNC_LEN;
            end
            PH_FILE: begin
                adv_fl    = fl_dec;
                adv_phase = (fl_dec == '0) ? PH_FUNC_LEN : PH_FILE;
            end
            PH_FUNC_LEN: begin
                adv_fl    = b;
                adv_phase = (b != '0) ? PH_FUNC : PH_TAG_CNT;
            end
            PH_FUNC: begin
                adv_fl    = fl_dec;
                adv_phase = (fl_dec == '0) ? PH_TAG_CNT : PH_FUNC;
            end
            PH_TAG_CNT: begin
                adv_tl    = b;
                adv_phase = (b != '0) ? PH_TAG_LEN : PH_DATA_CNT;
            end
            PH_TAG_LEN: begin
                adv_fl = b;
                if (b != '0) begin
                    adv_phase = PH_TAG;
                end else begin
                    adv_tl    = tl_dec;
                    adv_phase = (tl_dec != '0) ? PH_TAG_LEN : PH_DATA_CNT;
                end
            end
            PH_TAG: begin
                adv_fl = fl_dec;
                if (fl_dec == '0) begin
                    adv_tl    = tl_dec;
                    adv_phase = (tl_dec != '0) ? PH_TAG_LEN : PH_DATA_CNT;
                end
            end
            PH_DATA_CNT: begin
                adv_il    = b;
                adv_phase = (b != '0) ? PH_ITEM_TYPE : PH_DONE;
            end
            PH_ITEM_TYPE: begin
                adv_phase = PH_NAME_LEN;
            end
            PH_NAME_LEN: begin
                adv_fl    = b;
                adv_phase = (b != '0) ? PH_NAME : PH_VAL_LEN;
            end
            PH_NAME: begin
                adv_fl    = fl_dec;
                adv_phase = (fl_dec == '0) ? PH_VAL_LEN : PH_NAME;
            end
            PH_VAL_LEN: begin
                adv_fl = b;
                if (b != '0) begin
                    adv_phase = PH_VAL;
                end else begin
                    adv_il    = il_dec;
                    adv_phase = (il_dec != '0) ? PH_ITEM_TYPE : PH_DONE;
                end
            end
            PH_VAL: begin
                adv_fl = fl_dec;
                if (fl_dec == '0) begin
                    adv_il    = il_dec;
                    adv_phase = (il_dec != '0) ? PH_ITEM_TYPE : PH_DONE;
                end
            end
            default: begin
                // header bytes, and any code that cannot occur
                adv_phase = (cnt_inc >= CW'(HEADER_BYTES)) ? PH_LVL_LEN : PH_HDR;
            end
        endcase
    end

    // frame state update and result forming
    always_comb begin
        n_hunting    = r_hunting;
        n_phase      = r_phase;
        n_field_left = r_field_left;
        n_tags_left  = r_tags_left;
        n_items_left = r_items_left;
        n_byte_count = r_byte_count;
        n_level      = r_level;
        produce      = 1'b0;
        res          = '0;
        if (o_pop) begin
            case (i_head.ent.kind)
                KIND_LEVEL: begin
                    n_level      = b;
                    produce      = 1'b1;
                    res.tx_valid = 1'b1;
                    res.tx_byte  = b;
                end
                KIND_SYNC: begin
                    produce      = 1'b1;
                    res.tx_valid = 1'b1;
                    res.tx_byte  = ACK_BYTE;
                    if (!r_hunting) begin
                        res.frame_abort  = 1'b1;
                        res.frame_length = LEN_W'(r_byte_count);
                    end
                    n_hunting    = 1'b0;
                    n_phase      = PH_HDR;
                    n_field_left = '0;
                    n_tags_left  = '0;
                    n_items_left = '0;
                    n_byte_count = '0;
                end
                KIND_DATA: begin
                    if (!r_hunting) begin
                        produce          = 1'b1;
                        res.frame_valid  = 1'b1;
                        res.frame_byte   = b;
                        res.frame_length = LEN_W'(cnt_inc);
                        if (adv_phase == PH_DONE) begin
                            res.tx_valid   = 1'b1;
                            res.tx_byte    = r_level;
                            res.frame_done = 1'b1;
                            n_hunting      = 1'b1;
                            n_phase        = PH_HDR;
                            n_field_left   = '0;
                            n_tags_left    = '0;
                            n_items_left   = '0;
                            n_byte_count   = '0;
                        end else if (cnt_inc >= CW'(MAX_FRAME)) begin
                            res.frame_abort = 1'b1;
                            n_hunting       = 1'b1;
                            n_phase         = PH_HDR;
                            n_field_left    = '0;
                            n_tags_left     = '0;
                            n_items_left    = '0;
                            n_byte_count    = '0;
                        end else begin
                            n_phase      = adv_phase;
                            n_field_left = adv_fl;
                            n_tags_left  = adv_tl;
                            n_items_left = adv_il;
                            n_byte_count = cnt_inc;
                        end
                    end
                end
                default: begin
                    produce = 1'b0;
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting    <= 1'b1;
            r_phase      <= PH_HDR;
            r_field_left <= '0;
            r_tags_left  <= '0;
            r_items_left <= '0;
            r_byte_count <= '0;
            r_level      <= '0;
        end else begin
            r_hunting    <= n_hunting;
            r_phase      <= n_phase;
            r_field_left <= n_field_left;
            r_tags_left  <= n_tags_left;
            r_items_left <= n_items_left;
            r_byte_count <= n_byte_count;
            r_level      <= n_level;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= o_pop && produce;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (o_pop && produce) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
